// ===== design/cnt_pkg.sv =====
// ----------------------------------------------------------------------------
// cnt_pkg
// Shared constants and types for the code nesting tracker: command codes,
// character codes, the per-character class word and the queued item beat.
// ----------------------------------------------------------------------------
package cnt_pkg;

    // Counter width for the bracket depths and the colon line count
    localparam int COUNT_BITS = 16;

    // Width of the character input and of the reported fields
    localparam int CHAR_W = 16;
    localparam int OUT_W  = 16;

    // Front-to-back item queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Command codes
    localparam logic [1:0] CMD_CHAR   = 2'd0;
    localparam logic [1:0] CMD_EOL    = 2'd1;
    localparam logic [1:0] CMD_FINAL  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_TAB     = 16'h0009;
    localparam logic [CHAR_W-1:0] CH_CR      = 16'h000D;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_DQUOTE  = 16'h0022;
    localparam logic [CHAR_W-1:0] CH_HASH    = 16'h0023;
    localparam logic [CHAR_W-1:0] CH_SQUOTE  = 16'h0027;
    localparam logic [CHAR_W-1:0] CH_LROUND  = 16'h0028;
    localparam logic [CHAR_W-1:0] CH_RROUND  = 16'h0029;
    localparam logic [CHAR_W-1:0] CH_COLON   = 16'h003A;
    localparam logic [CHAR_W-1:0] CH_LSQUARE = 16'h005B;
    localparam logic [CHAR_W-1:0] CH_BSLASH  = 16'h005C;
    localparam logic [CHAR_W-1:0] CH_RSQUARE = 16'h005D;
    localparam logic [CHAR_W-1:0] CH_LCURLY  = 16'h007B;
    localparam logic [CHAR_W-1:0] CH_RCURLY  = 16'h007D;

    // One-hot-ish class of a character; the back end never sees the code
    typedef struct packed {
        logic ws;       // ASCII whitespace
        logic sp_tab;   // space or tab
        logic sq;       // single quote
        logic dq;       // double quote
        logic hash;
        logic colon;
        logic lround;
        logic rround;
        logic lcurly;
        logic rcurly;
        logic lsquare;
        logic rsquare;
        logic bslash;
    } char_class_t;

    // Beat moved through the item queue
    typedef struct packed {
        logic [1:0]  cmd;
        char_class_t cls;
    } item_t;

endpackage

// ===== design/code_nesting_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// code_nesting_tracker_unit
// Bracket, string, comment and colon tracker for Python-like source text.
//
// Input channel (push/full): one beat per character (cmd 0 with ch), per
// line end (cmd 1) or per final line end (cmd 2); cmd 3 beats are dropped.
// Result channel (empty/pop): one beat per final line end carrying curly and
// round depth, colon line count and the string and comment flags; the
// tracker then starts over from its reset state.
// Throughput: one input beat per cycle while full stays low; the back end
// applies each queued item as it is taken. A result passes from the input
// stage through the item queue into the result register, and waits longer
// if the queue holds earlier beats.
// Reset clears all counters and flags, empties the queue and the result
// register. While a result waits unpopped, character and line beats keep
// flowing; a further final-line beat waits in the queue until the pending
// result is popped, and full rises once the queue and input stage fill.
// ----------------------------------------------------------------------------
module code_nesting_tracker_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [1:0]                         cmd,
    input  logic [cnt_pkg::CHAR_W-1:0]         ch,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [cnt_pkg::OUT_W-1:0]   curly_depth,
    output logic signed [cnt_pkg::OUT_W-1:0]   round_depth,
    output logic [cnt_pkg::OUT_W-1:0]          colon_lines,
    output logic                               in_string,
    output logic                               in_comment
);
    import cnt_pkg::*;

    logic  q_wr;
    logic  q_full;
    item_t q_wr_data;
    item_t q_rd_data;
    logic  q_empty;
    logic  q_pop;

    cnt_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .cmd    (cmd),
        .ch     (ch),
        .q_wr   (q_wr),
        .q_data (q_wr_data),
        .q_full (q_full)
    );

    cnt_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    cnt_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (q_rd_data),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .curly_depth (curly_depth),
        .round_depth (round_depth),
        .colon_lines (colon_lines),
        .in_string   (in_string),
        .in_comment  (in_comment)
    );

endmodule

// ===== design/cnt_front.sv =====
// ----------------------------------------------------------------------------
// cnt_front
// Input stage: accepts command beats, classifies the character and drops
// unused commands, then hands classified items to the item queue.
// ----------------------------------------------------------------------------
module cnt_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  cmd,
    input  logic [cnt_pkg::CHAR_W-1:0]  ch,
    output logic                        q_wr,
    output cnt_pkg::item_t              q_data,
    input  logic                        q_full
);
    import cnt_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  ready;
    logic  accept;

    // Character classifier
    function automatic char_class_t classify(logic [CHAR_W-1:0] c);
        char_class_t k;
        k.ws      = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        k.sp_tab  = (c == CH_SPACE) || (c == CH_TAB);
        k.sq      = (c == CH_SQUOTE);
        k.dq      = (c == CH_DQUOTE);
        k.hash    = (c == CH_HASH);
        k.colon   = (c == CH_COLON);
        k.lround  = (c == CH_LROUND);
        k.rround  = (c == CH_RROUND);
        k.lcurly  = (c == CH_LCURLY);
        k.rcurly  = (c == CH_RCURLY);
        k.lsquare = (c == CH_LSQUARE);
        k.rsquare = (c == CH_RSQUARE);
        k.bslash  = (c == CH_BSLASH);
        return k;
    endfunction

    // Handshake: stage frees up whenever the queue takes its beat
    assign q_wr   = valid_reg && !q_full;
    assign ready  = !valid_reg || !q_full;
    assign full   = !ready;
    assign accept = push && ready;
    assign q_data = item_reg;

    // Next stage contents; unused commands are consumed here
    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (accept && (cmd != CMD_UNUSED))
        begin
            valid_next    = 1'b1;
            item_next.cmd = cmd;
            item_next.cls = classify(ch);
        end
        else if (q_wr)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ===== design/cnt_queue.sv =====
// ----------------------------------------------------------------------------
// cnt_queue
// Small show-ahead queue of classified items between front and back end.
// ----------------------------------------------------------------------------
module cnt_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  cnt_pkg::item_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output cnt_pkg::item_t rd_data,
    output logic           empty
);
    import cnt_pkg::*;

    item_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                do_wr;
    logic                do_rd;

    // Pointer wrap that does not rely on a power-of-two depth
    function automatic logic [QUEUE_AW-1:0] ptr_inc(logic [QUEUE_AW-1:0] p);
        return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full    = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = do_wr ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_rd ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/cnt_back.sv =====
// ----------------------------------------------------------------------------
// cnt_back
// Scanner: applies one queued item per cycle (a final one waits while a
// result is held) to lookahead, string, comment, counter and result state.
// ----------------------------------------------------------------------------
module cnt_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cnt_pkg::item_t                     q_data,
    input  logic                               q_empty,
    output logic                               q_pop,
    input  logic                               pop,
    output logic                               empty,
    output logic signed [cnt_pkg::OUT_W-1:0]   curly_depth,
    output logic signed [cnt_pkg::OUT_W-1:0]   round_depth,
    output logic [cnt_pkg::OUT_W-1:0]          colon_lines,
    output logic                               in_string,
    output logic                               in_comment
);
    import cnt_pkg::*;

    typedef logic signed [COUNT_BITS-1:0] depth_t;
    typedef logic [COUNT_BITS-1:0]        count_t;

    localparam depth_t DEPTH_MAX = {1'b0, {(COUNT_BITS - 1){1'b1}}};
    localparam depth_t DEPTH_MIN = {1'b1, {(COUNT_BITS - 1){1'b0}}};

    // Complete scanner state
    typedef struct packed {
        char_class_t la0;
        char_class_t la1;
        logic [1:0]  la_fill;
        logic        prev_bslash;
        logic        line_started;
        logic        block_open;
        logic        block_dq;
        logic        string_open;
        logic        string_dq;
        logic        line_in_comment;
        logic        line_has_colon;
        logic        colon_blocked;
        depth_t      curly_count;
        depth_t      round_count;
        count_t      colon_count;
        logic        string_flag;
        logic        comment_flag;
        logic        line_all_blank;
        logic        line_leads_blank;
        logic        ws_pending;
    } scan_t;

    scan_t st_reg;
    scan_t st_next;
    scan_t fin;
    logic  out_valid_reg;
    logic  out_valid_next;
    logic  take;
    logic  emit;

    logic signed [OUT_W-1:0] curly_reg;
    logic signed [OUT_W-1:0] round_reg;
    logic [OUT_W-1:0]        colon_reg;
    logic                    string_reg;
    logic                    comment_reg;

    function automatic scan_t reset_state();
        scan_t r;
        r = '0;
        r.line_all_blank = 1'b1;
        return r;
    endfunction

    function automatic scan_t clear_line(scan_t s);
        scan_t r;
        r = s;
        r.la0              = '0;
        r.la1              = '0;
        r.la_fill          = 2'd0;
        r.prev_bslash      = 1'b0;
        r.line_started     = 1'b0;
        r.line_in_comment  = 1'b0;
        r.line_has_colon   = 1'b0;
        r.line_all_blank   = 1'b1;
        r.line_leads_blank = 1'b0;
        r.ws_pending       = 1'b0;
        return r;
    endfunction

    // Saturating depth step
    function automatic depth_t depth_step(depth_t v, logic inc, logic dec);
        depth_t r;
        r = v;
        if (inc && (v != DEPTH_MAX))
        begin
            r = v + depth_t'(1);
        end
        else if (dec && (v != DEPTH_MIN))
        begin
            r = v - depth_t'(1);
        end
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] depth_out(depth_t v);
        logic signed [31:0] w;
        w = 32'(v);
        return w[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] count_out(count_t v);
        logic [31:0] w;
        w = 32'(v);
        return w[OUT_W-1:0];
    endfunction

    // Scan of one character that left the lookahead
    function automatic scan_t scan_plain(scan_t s, char_class_t c);
        scan_t r;
        r = s;
        if (!c.ws && r.ws_pending)
        begin
            r.comment_flag = r.line_in_comment;
            r.ws_pending   = 1'b0;
        end
        if (!r.block_open)
        begin
            if (c.sq || c.dq)
            begin
                if (!r.string_open)
                begin
                    r.string_open = 1'b1;
                    r.string_dq   = c.dq;
                end
                else if ((r.string_dq == c.dq) && r.line_started && !r.prev_bslash)
                begin
                    r.string_open = 1'b0;
                end
            end
            r.string_flag = r.string_open;
            if (!r.string_open)
            begin
                if (c.hash)
                begin
                    r.line_in_comment = 1'b1;
                end
                if (c.ws)
                begin
                    r.ws_pending = 1'b1;
                end
                else
                begin
                    r.comment_flag = r.line_in_comment;
                end
                if (!r.line_in_comment)
                begin
                    if (!r.colon_blocked && c.colon)
                    begin
                        r.line_has_colon = 1'b1;
                    end
                    if (c.lround || c.rround)
                    begin
                        r.round_count = depth_step(r.round_count, c.lround, c.rround);
                    end
                    else if (c.lcurly || c.rcurly)
                    begin
                        r.curly_count   = depth_step(r.curly_count, c.lcurly, c.rcurly);
                        r.colon_blocked = c.lcurly;
                    end
                    else if (c.lsquare || c.rsquare)
                    begin
                        r.colon_blocked = c.lsquare;
                    end
                end
            end
        end
        r.prev_bslash  = c.bslash;
        r.line_started = 1'b1;
        return r;
    endfunction

    // New character: fill lookahead, or check for a triple quote, else scan la0
    function automatic scan_t take_char(scan_t s, char_class_t c);
        scan_t r;
        logic  triple;
        r = s;
        if ((r.la_fill == 2'd0) && !r.line_started)
        begin
            r.line_leads_blank = c.sp_tab;
        end
        if (!c.ws)
        begin
            r.line_all_blank = 1'b0;
        end
        triple = ((s.la0.sq && s.la1.sq && c.sq) || (s.la0.dq && s.la1.dq && c.dq))
                 && (!s.block_open || (s.la0.dq == s.block_dq));
        if (r.la_fill != 2'd2)
        begin
            if (r.la_fill == 2'd0)
            begin
                r.la0 = c;
            end
            else
            begin
                r.la1 = c;
            end
            r.la_fill = r.la_fill + 2'd1;
        end
        else if (triple)
        begin
            if (r.ws_pending)
            begin
                r.comment_flag = r.line_in_comment;
                r.ws_pending   = 1'b0;
            end
            r.block_open   = !s.block_open;
            r.block_dq     = !s.block_open && s.la0.dq;
            r.prev_bslash  = c.bslash;
            r.line_started = 1'b1;
            r.la_fill      = 2'd0;
        end
        else
        begin
            r     = scan_plain(r, s.la0);
            r.la0 = s.la1;
            r.la1 = c;
        end
        return r;
    endfunction

    // Line end: drain lookahead, settle comment flag and colon count
    function automatic scan_t finish_line(scan_t s, logic final_line);
        scan_t r;
        r = s;
        if (s.la_fill != 2'd0)
        begin
            r = scan_plain(r, s.la0);
        end
        if (s.la_fill == 2'd2)
        begin
            r = scan_plain(r, s.la1);
        end
        if (r.ws_pending && r.line_all_blank && r.line_leads_blank)
        begin
            r.comment_flag = r.line_in_comment;
        end
        if (r.line_has_colon && (r.colon_count != '1))
        begin
            r.colon_count = r.colon_count + 1'b1;
        end
        if (final_line && r.line_all_blank && !r.line_leads_blank && !r.block_open)
        begin
            r.colon_count = '0;
        end
        return r;
    endfunction

    // Only a final-line item needs room in the result register
    assign take  = !q_empty && ((q_data.cmd != CMD_FINAL) || !out_valid_reg || pop);
    assign q_pop = take;
    assign emit  = take && (q_data.cmd == CMD_FINAL);
    assign fin   = finish_line(st_reg, q_data.cmd == CMD_FINAL);

    // Scanner state update
    always_comb
    begin
        st_next = st_reg;
        if (take)
        begin
            case (q_data.cmd)
                CMD_CHAR:  st_next = take_char(st_reg, q_data.cls);
                CMD_EOL:   st_next = clear_line(fin);
                CMD_FINAL: st_next = reset_state();
                default:   st_next = st_reg;
            endcase
        end
    end

    // Result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= reset_state();
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            curly_reg   <= depth_out(fin.curly_count);
            round_reg   <= depth_out(fin.round_count);
            colon_reg   <= count_out(fin.colon_count);
            string_reg  <= fin.string_flag;
            comment_reg <= fin.comment_flag;
        end
    end

    assign empty       = !out_valid_reg;
    assign curly_depth = curly_reg;
    assign round_depth = round_reg;
    assign colon_lines = colon_reg;
    assign in_string   = string_reg;
    assign in_comment  = comment_reg;

endmodule
